/* sv/ctre_pkg.sv */
package ctre_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int GLYPH_W      = 16;
  localparam int CLASS_W      = 16;
  localparam int TOTAL_W      = 7;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [CLASS_W-1:0] cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/ctre_ram.sv */
module ctre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/class_table_range_encoder.sv */
// Class table range encoder.
// Input channel (in_valid / in_stall): one glyph/class pair per transaction.
// Pairs with class 0 are dropped; others are inserted into a sorted store
// (one RAM, insertion sort: the new pair walks down from the top, moving one
// entry per cycle: the compare and write of one entry overlap the next read).
// After acceptance in_stall stays high while every entry with a larger glyph
// id moves up one slot; a dropped pair or a pair into an empty store skips this.
// A transaction with in_last_entry set closes the set: after its own pair is
// inserted, the store is scanned twice (read, then evaluate, per entry) to
// count the ranges, then to emit them, so every range carries the final total.
// Output channel (out_valid / out_stall): one range per transaction from a
// single output register; the scan holds while the receiver stalls.
// An empty set yields the single range 0..0 class 1.
// in_stall is high from acceptance until the last range of a set is taken
// (or, for a non-final pair, until insertion is done).
// Synchronous active-low reset empties the store and clears the overflow flag;
// RAM contents are not cleared, only entries below the fill count are read.
module class_table_range_encoder #(
  parameter int CAPACITY = ctre_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctre_pkg::GLYPH_W-1:0]  in_glyph_id,
  input  logic [ctre_pkg::CLASS_W-1:0]  in_class_id,
  input  logic                          in_last_entry,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ctre_pkg::GLYPH_W-1:0]  out_range_start,
  output logic [ctre_pkg::GLYPH_W-1:0]  out_range_end,
  output logic [ctre_pkg::CLASS_W-1:0]  out_range_class,
  output logic [ctre_pkg::TOTAL_W-1:0]  out_range_total,
  output logic                          out_overflowed,
  output logic                          out_last_range
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GW = ctre_pkg::GLYPH_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SH_CMP   = 4'd1;
  localparam logic [3:0] S_WR_NEW   = 4'd2;
  localparam logic [3:0] S_CHK_LAST = 4'd3;
  localparam logic [3:0] S_CNT_RD   = 4'd4;
  localparam logic [3:0] S_CNT_EV   = 4'd5;
  localparam logic [3:0] S_EM_RD    = 4'd6;
  localparam logic [3:0] S_EM_EV    = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic        ovf_r, ovf_nxt;
  logic        last_r, last_nxt;
  ctre_pkg::entry_t new_r, new_nxt;
  ctre_pkg::entry_t cur_s_r, cur_s_nxt;  // start glyph and class of the open range
  logic [GW-1:0] cur_e_r, cur_e_nxt;

  logic        ov_r, ov_nxt;
  logic        ol_r, ol_nxt;
  logic [GW-1:0] os_r, os_nxt, oe_r, oe_nxt;
  logic [ctre_pkg::CLASS_W-1:0] oc_r, oc_nxt;
  logic        oovf_r, oovf_nxt;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ctre_pkg::entry_t ram_wdata, ram_rdata;

  logic        joins;
  logic [CW-1:0] k_inc;

  ctre_ram #(
    .WIDTH (ctre_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A stored entry extends the open range when its id follows the end
  // directly (no wrap past the top id) and the class matches.
  assign joins = ({1'b0, ram_rdata.glyph} == ({1'b0, cur_e_r} + {{GW{1'b0}}, 1'b1}))
                 && (ram_rdata.cls == cur_s_r.cls);
  assign k_inc = k_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    new_nxt   = new_r;
    cur_s_nxt = cur_s_r;
    cur_e_nxt = cur_e_r;
    ov_nxt    = ov_r;
    ol_nxt    = ol_r;
    os_nxt    = os_r;
    oe_nxt    = oe_r;
    oc_nxt    = oc_r;
    oovf_nxt  = oovf_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r[AW-1:0];
    ram_wdata = new_r;
    ram_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.glyph = in_glyph_id;
          new_nxt.cls   = in_class_id;
          last_nxt      = in_last_entry;
          state_nxt     = S_CHK_LAST;
          if (in_class_id != '0) begin
            if (count_r == CW'(CAPACITY)) begin
              ovf_nxt = 1'b1;
            end else if (count_r == '0) begin
              // Empty store: write straight to the bottom.
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{glyph: in_glyph_id, cls: in_class_id};
              count_nxt = CW'(1);
            end else begin
              pos_nxt   = count_r;
              ram_raddr = AW'(count_r - CW'(1));
              state_nxt = S_SH_CMP;
            end
          end
        end
      end
      S_SH_CMP: begin
        if (ram_rdata.glyph > new_r.glyph) begin
          // Move the larger entry up one slot and look further down.
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = S_WR_NEW;
          end else begin
            ram_raddr = AW'(pos_r - CW'(2));
          end
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_CHK_LAST;
        end
      end
      S_WR_NEW: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_CHK_LAST;
      end
      S_CHK_LAST: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (count_r == '0) begin
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          os_nxt    = '0;
          oe_nxt    = '0;
          oc_nxt    = ctre_pkg::CLASS_W'(1);
          n_nxt     = CW'(1);
          oovf_nxt  = ovf_r;
          state_nxt = S_OUT;
        end else begin
          k_nxt     = '0;
          n_nxt     = '0;
          state_nxt = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_CNT_EV;
      end
      S_CNT_EV: begin
        if (k_r != '0 && joins) begin
          cur_e_nxt = ram_rdata.glyph;
        end else begin
          n_nxt     = n_r + CW'(1);
          cur_s_nxt = ram_rdata;
          cur_e_nxt = ram_rdata.glyph;
        end
        k_nxt = k_inc;
        if (k_inc == count_r) begin
          k_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_CNT_RD;
        end
      end
      S_EM_RD: begin
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_EM_EV;
      end
      S_EM_EV: begin
        k_nxt = k_inc;
        if (k_r != '0 && !joins) begin
          // Close the open range and start a new one with this entry.
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b0;
          os_nxt    = cur_s_r.glyph;
          oe_nxt    = cur_e_r;
          oc_nxt    = cur_s_r.cls;
          oovf_nxt  = ovf_r;
          cur_s_nxt = ram_rdata;
          cur_e_nxt = ram_rdata.glyph;
          state_nxt = S_OUT;
        end else begin
          if (k_r == '0) begin
            cur_s_nxt = ram_rdata;
          end
          cur_e_nxt = ram_rdata.glyph;
          if (k_inc == count_r) begin
            ov_nxt    = 1'b1;
            ol_nxt    = 1'b1;
            os_nxt    = (k_r == '0) ? ram_rdata.glyph : cur_s_r.glyph;
            oe_nxt    = ram_rdata.glyph;
            oc_nxt    = (k_r == '0) ? ram_rdata.cls : cur_s_r.cls;
            oovf_nxt  = ovf_r;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      S_OUT: begin
        if (ov_r && !out_stall) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            // Set complete: empty the store for the next one.
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else if (k_r == count_r) begin
            ov_nxt   = 1'b1;
            ol_nxt   = 1'b1;
            os_nxt   = cur_s_r.glyph;
            oe_nxt   = cur_e_r;
            oc_nxt   = cur_s_r.cls;
            oovf_nxt = ovf_r;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    last_r  <= last_nxt;
    new_r   <= new_nxt;
    cur_s_r <= cur_s_nxt;
    cur_e_r <= cur_e_nxt;
    ol_r    <= ol_nxt;
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
    oc_r    <= oc_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_range_start = os_r;
  assign out_range_end   = oe_r;
  assign out_range_class = oc_r;
  assign out_range_total = ctre_pkg::TOTAL_W'(n_r);
  assign out_overflowed  = oovf_r;
  assign out_last_range  = ol_r;

`ifndef SYNTHESIS
  a_no_out_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result pending while accepting input");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("store count beyond capacity");
  a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_range |=> count_r == '0 && !ovf_r)
    else $error("store not cleared after final range");
`endif

endmodule

/* dv/class_table_range_encoder_test.sv */
`timescale 1ns / 1ps

module class_table_range_encoder_test;
  import ctre_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [GLYPH_W-1:0] start;
    logic [GLYPH_W-1:0] stop;
    logic [CLASS_W-1:0] cls;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
    logic               last;
  } range_t;

  // Sorted pair store plus the queue of ranges still owed by the block.
  class range_scoreboard;
    logic [GLYPH_W-1:0] glyph_store[$];
    logic [CLASS_W-1:0] class_store[$];
    bit                 overflow;
    range_t             owed_ranges[$];
    int                 mismatches;
    int                 ranges_seen;
    int                 sets_closed;

    function void note_pair(logic [GLYPH_W-1:0] g, logic [CLASS_W-1:0] c, bit last);
      int     pos;
      range_t found[$];
      range_t r;
      int     k;
      if (c != 0) begin
        if (glyph_store.size() < CAP) begin
          pos = glyph_store.size();
          while (pos > 0 && glyph_store[pos-1] > g) pos--;
          glyph_store.insert(pos, g);
          class_store.insert(pos, c);
        end else begin
          overflow = 1;
        end
      end
      if (!last) return;
      sets_closed++;
      if (glyph_store.size() == 0) begin
        r = '0;
        r.cls = CLASS_W'(1);
        found.push_back(r);
      end else begin
        r = '0;
        r.start = glyph_store[0];
        r.stop  = glyph_store[0];
        r.cls   = class_store[0];
        for (k = 1; k < glyph_store.size(); k++) begin
          // 65535 has no successor, so compare in wide arithmetic
          if (int'(glyph_store[k]) == int'(r.stop) + 1 && class_store[k] == r.cls) begin
            r.stop = glyph_store[k];
          end else begin
            found.push_back(r);
            r.start = glyph_store[k];
            r.stop  = glyph_store[k];
            r.cls   = class_store[k];
          end
        end
        found.push_back(r);
      end
      foreach (found[i]) begin
        r = found[i];
        r.total = TOTAL_W'(found.size());
        r.ovf   = overflow;
        r.last  = (i == found.size() - 1);
        owed_ranges.push_back(r);
      end
      glyph_store.delete();
      class_store.delete();
      overflow = 0;
    endfunction

    function void check_range(range_t got);
      range_t want;
      ranges_seen++;
      if (owed_ranges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected range start=%0d end=%0d class=%0d", got.start,
                   got.stop, got.cls);
        return;
      end
      want = owed_ranges.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: range mismatch exp start=%0d end=%0d class=%0d total=%0d ",
                    "ovf=%0d last=%0d got start=%0d end=%0d class=%0d total=%0d ",
                    "ovf=%0d last=%0d"},
                   want.start, want.stop, want.cls, want.total, want.ovf, want.last,
                   got.start, got.stop, got.cls, got.total, got.ovf, got.last);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [GLYPH_W-1:0] in_glyph_id;
  logic [CLASS_W-1:0] in_class_id;
  logic               in_last_entry;
  logic               out_valid;
  logic               out_stall;
  logic [GLYPH_W-1:0] out_range_start;
  logic [GLYPH_W-1:0] out_range_end;
  logic [CLASS_W-1:0] out_range_class;
  logic [TOTAL_W-1:0] out_range_total;
  logic               out_overflowed;
  logic               out_last_range;

  range_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  cycle_count;
  int  pairs_sent;

  class_table_range_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_id     (in_glyph_id),
    .in_class_id     (in_class_id),
    .in_last_entry   (in_last_entry),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_range_start (out_range_start),
    .out_range_end   (out_range_end),
    .out_range_class (out_range_class),
    .out_range_total (out_range_total),
    .out_overflowed  (out_overflowed),
    .out_last_range  (out_last_range)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall at the falling edge; a hold request forces a long
  // stall so the block holds its output and pushes back on the sender.
  initial begin
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = 400;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Monitor: take one range per accepted transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_range({out_range_start, out_range_end, out_range_class, out_range_total,
                      out_overflowed, out_last_range});
  end

  // Offer one pair; hold it until the block takes the transaction.
  task automatic send_pair(logic [GLYPH_W-1:0] g, logic [CLASS_W-1:0] c, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_glyph_id   <= g;
    in_class_id   <= c;
    in_last_entry <= last;
    do @(posedge clk); while (in_stall);
    sb.note_pair(g, c, last);
    pairs_sent++;
  endtask

  // Random set: clustered ids so neighbors merge, a few classes, some noise.
  task automatic send_random_set(int n);
    logic [GLYPH_W-1:0] base;
    logic [GLYPH_W-1:0] g;
    logic [CLASS_W-1:0] c;
    int                 flavor;
    flavor = $urandom_range(0, 9);
    base   = (flavor == 0) ? 16'hFFF8 : GLYPH_W'($urandom_range(0, 65535 - 16));
    for (int i = 0; i < n; i++) begin
      if (flavor == 1) g = GLYPH_W'($urandom_range(0, 65535));
      else g = base + GLYPH_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) c = '0;
      else if (flavor == 2) c = CLASS_W'($urandom_range(0, 65535));
      else c = CLASS_W'($urandom_range(1, 2));
      send_pair(g, c, i == n - 1);
    end
  endtask

  initial begin
    int phase;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_glyph_id   = '0;
    in_class_id   = '0;
    in_last_entry = 1'b0;
    hold_request  = 0;
    send_idle_pct = 19;
    recv_idle_pct = 54;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty set: default range.
    send_pair(16'd100, 16'd0, 1);
    // Top id does not wrap to zero.
    send_pair(16'hFFFF, 16'd1, 0);
    send_pair(16'h0000, 16'd1, 0);
    send_pair(16'hFFFE, 16'd1, 0);
    send_pair(16'h0001, 16'd1, 1);
    // Repeated id never merges.
    send_pair(16'd5, 16'd3, 0);
    send_pair(16'd5, 16'd3, 0);
    send_pair(16'd6, 16'd3, 0);
    send_pair(16'd4, 16'd3, 1);
    // Class change splits; widest values; dropped pair closing a set.
    send_pair(16'd10, 16'd1, 0);
    send_pair(16'd11, 16'd2, 0);
    send_pair(16'd12, 16'd2, 0);
    send_pair(16'hFFFF, 16'hFFFF, 0);
    send_pair(16'hAAAA, 16'h5555, 0);
    send_pair(16'h5555, 16'hAAAA, 0);
    send_pair(16'd13, 16'd0, 1);

    // Overflow: more nonzero pairs than the store holds.
    for (int i = 0; i < CAP + 4; i++)
      send_pair(GLYPH_W'($urandom_range(0, 200)), CLASS_W'($urandom_range(1, 3)),
                i == CAP + 3);

    phase = 0;
    while (pairs_sent < 130) begin
      if (phase == 0 && pairs_sent >= 100) begin
        phase         = 1;
        send_idle_pct = 54;
        recv_idle_pct = 19;
      end else if (phase == 1 && pairs_sent >= 115) begin
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1;
      end
      if ($urandom_range(0, 11) == 0)
        send_pair(GLYPH_W'($urandom_range(0, 65535)), '0, 1);
      else send_random_set($urandom_range(1, 12));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed_ranges.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Run covered %0d pairs in %0d sets, %0d ranges checked.", pairs_sent,
             sb.sets_closed, sb.ranges_seen);
    if (sb.mismatches == 0 && sb.owed_ranges.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, ranges still owed: %0d", sb.mismatches,
               sb.owed_ranges.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
